// ===== src/aes_cmac_engine_defines.svh =====
// Assertion macros shared by the AES-CMAC engine RTL
`ifndef AES_CMAC_ENGINE_DEFINES_SVH
`define AES_CMAC_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define ACM_ASSERT_IMP(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("acm same-cycle check failed");

// Next-cycle implication, disabled during reset
`define ACM_ASSERT_NEXT(name, clk, rst_n, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("acm next-cycle check failed");

`endif

// ===== src/acm_pkg.sv =====
// Shared types, constants and AES functions of the AES-CMAC engine
package acm_pkg;

    localparam int BLOCK_BYTES = 16;
    localparam int RK_ROWS     = 15;
    localparam logic [7:0] CMAC_RB  = 8'h87;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_SUBKEY,
        ST_BLOCK,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        REG_KEY_WORD_0,
        REG_KEY_WORD_1,
        REG_KEY_WORD_2,
        REG_KEY_WORD_3,
        REG_KEY_BYTES,
        REG_MAC_BYTES
    } reg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_BAD_MAC,
        STATUS_BAD_KEY
    } status_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  row;
        logic [1:0]  lane;
        logic [31:0] data;
    } rk_wr_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // SubBytes, ShiftRows and, except in the final round, MixColumns
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic final_round);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int k = 0; k < 16; k++) begin
            b[k] = SBOX[s[127 - 8 * k -: 8]];
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[4 * c + i] = b[4 * ((c + i) % 4) + i];
            end
        end
        r = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = t[4 * c];
            a1  = t[4 * c + 1];
            a2  = t[4 * c + 2];
            a3  = t[4 * c + 3];
            all = a0 ^ a1 ^ a2 ^ a3;
            if (final_round) begin
                r[127 - 32 * c -: 32] = {a0, a1, a2, a3};
            end
            else begin
                r[127 - 32 * c -: 32] = {a0 ^ all ^ xtime(a0 ^ a1), a1 ^ all ^ xtime(a1 ^ a2),
                                         a2 ^ all ^ xtime(a2 ^ a3), a3 ^ all ^ xtime(a3 ^ a0)};
            end
        end
        return r;
    endfunction

    function automatic logic [127:0] double_block(input logic [127:0] x);
        return {x[126:0], 1'b0} ^ (x[127] ? {120'd0, CMAC_RB} : 128'd0);
    endfunction

endpackage

// ===== src/aes_cmac_engine.sv =====
// AES-CMAC engine top level: control, chaining, subkeys, padding and tag output
//
//  channel   signals                                   direction
//  input     in_valid/in_ready, data_hi, data_lo,      request in
//            valid_bytes, last
//  output    out_valid/out_ready, mac_hi, mac_lo,      request out
//            status
//  config    cfg_we, cfg_index, cfg_data               write only
//
// A block's time from request to request is set by the cipher and its round count nr;
// a last block also loads the result register.
// The first block of a message first runs key expansion and the cipher pass for L.
// A block that fails a length check skips the cipher.
// Reset clears control, chain and subkey-ready state; the key memory needs no clearing.
// A result waits in the output register; a new request is taken while it waits.
module aes_cmac_engine
    import acm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] data_hi,
    input  logic [63:0] data_lo,
    input  logic [4:0]  valid_bytes,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] mac_hi,
    output logic [63:0] mac_lo,
    output logic [1:0]  status
);

`include "aes_cmac_engine_defines.svh"

    state_t       state_reg, state_next;
    logic         launch_reg;
    logic [63:0]  key_reg [4];
    logic [5:0]   key_bytes_reg;
    logic [4:0]   mac_bytes_reg;
    logic [127:0] blk_reg;
    logic [4:0]   vb_reg;
    logic         last_reg;
    status_t      status_reg;
    logic [127:0] chain_reg;
    logic [127:0] k1_reg;
    logic [127:0] k2_reg;
    logic         subkeys_ready_reg;
    logic         out_valid_reg;
    logic [127:0] out_mac_reg;
    status_t      out_status_reg;

    logic         accept;
    logic         key_ok;
    logic         mac_ok;
    logic         out_free;
    logic         key_write;
    logic [3:0]   nk;
    logic [3:0]   nr;
    logic [4:0]   vb_eff;
    logic [127:0] padded;
    logic [127:0] cbc_in;
    logic [127:0] tag_masked;
    logic [127:0] l_dbl;
    logic         kexp_start;
    logic         cipher_start;

    rk_wr_t       rk_wr;
    logic         kexp_busy;
    logic         kexp_done;
    logic [3:0]   rk_addr;
    logic [127:0] rk_data;
    logic [127:0] cipher_out;
    logic         cipher_busy;
    logic         cipher_done;

    assign nk       = key_bytes_reg[5:2];
    assign nr       = nk + 4'd6;
    assign key_ok   = key_bytes_reg == 6'd16 || key_bytes_reg == 6'd24 ||
                      key_bytes_reg == 6'd32;
    assign mac_ok   = mac_bytes_reg != 5'd0 && mac_bytes_reg <= 5'd16;
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign key_write = cfg_we && (cfg_index == REG_KEY_WORD_0 || cfg_index == REG_KEY_WORD_1 ||
                                  cfg_index == REG_KEY_WORD_2 || cfg_index == REG_KEY_WORD_3 ||
                                  cfg_index == REG_KEY_BYTES);

    // message padding and subkey mix
    always_comb
    begin
        if (!last_reg || vb_reg > 5'd16)
            vb_eff = 5'd16;
        else
            vb_eff = vb_reg;
        for (int k = 0; k < BLOCK_BYTES; k++)
        begin
            if (5'(k) < vb_eff)
                padded[127 - 8 * k -: 8] = blk_reg[127 - 8 * k -: 8];
            else if (5'(k) == vb_eff)
                padded[127 - 8 * k -: 8] = PAD_BYTE;
            else
                padded[127 - 8 * k -: 8] = 8'd0;
        end
        if (vb_eff == 5'd16)
            cbc_in = chain_reg ^ blk_reg ^ (last_reg ? k1_reg : 128'd0);
        else
            cbc_in = chain_reg ^ padded ^ k2_reg;
    end

    always_comb
    begin
        for (int k = 0; k < BLOCK_BYTES; k++)
        begin
            tag_masked[127 - 8 * k -: 8] =
                (5'(k) < mac_bytes_reg) ? cipher_out[127 - 8 * k -: 8] : 8'd0;
        end
    end

    assign l_dbl = double_block(cipher_out);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (last && !mac_ok)
                        state_next = ST_OUT;
                    else if (!key_ok)
                        state_next = last ? ST_OUT : ST_IDLE;
                    else if (!subkeys_ready_reg)
                        state_next = ST_EXPAND;
                    else
                        state_next = ST_BLOCK;
                end
            end
            ST_EXPAND:
            begin
                if (kexp_done)
                    state_next = ST_SUBKEY;
            end
            ST_SUBKEY:
            begin
                if (cipher_done)
                    state_next = ST_BLOCK;
            end
            ST_BLOCK:
            begin
                if (cipher_done)
                    state_next = last_reg ? ST_OUT : ST_IDLE;
            end
            ST_OUT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        in_ready     = 1'b0;
        kexp_start   = 1'b0;
        cipher_start = 1'b0;
        case (state_reg)
            ST_IDLE:   in_ready     = 1'b1;
            ST_EXPAND: kexp_start   = launch_reg;
            ST_SUBKEY: cipher_start = launch_reg;
            ST_BLOCK:  cipher_start = launch_reg;
            default:   in_ready     = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            launch_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            launch_reg <= (state_next != state_reg) &&
                          (state_next == ST_EXPAND || state_next == ST_SUBKEY ||
                           state_next == ST_BLOCK);
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < 4; j++)
            begin
                key_reg[j] <= '0;
            end
            key_bytes_reg <= 6'd16;
            mac_bytes_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KEY_WORD_0: key_reg[0]    <= cfg_data;
                REG_KEY_WORD_1: key_reg[1]    <= cfg_data;
                REG_KEY_WORD_2: key_reg[2]    <= cfg_data;
                REG_KEY_WORD_3: key_reg[3]    <= cfg_data;
                REG_KEY_BYTES:  key_bytes_reg <= cfg_data[5:0];
                REG_MAC_BYTES:  mac_bytes_reg <= cfg_data[4:0];
                default:        mac_bytes_reg <= mac_bytes_reg;
            endcase
        end
    end

    // chain and subkey state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg         <= '0;
            subkeys_ready_reg <= 1'b0;
        end
        else if (key_write || state_reg == ST_OUT)
        begin
            chain_reg         <= '0;
            subkeys_ready_reg <= 1'b0;
        end
        else if (state_reg == ST_SUBKEY && cipher_done)
            subkeys_ready_reg <= 1'b1;
        else if (state_reg == ST_BLOCK && cipher_done && !last_reg)
            chain_reg <= cipher_out;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            blk_reg  <= {data_hi, data_lo};
            vb_reg   <= valid_bytes;
            last_reg <= last;
            if (last && !mac_ok)
                status_reg <= STATUS_BAD_MAC;
            else if (!key_ok)
                status_reg <= STATUS_BAD_KEY;
            else
                status_reg <= STATUS_OK;
        end
        if (state_reg == ST_SUBKEY && cipher_done)
        begin
            k1_reg <= l_dbl;
            k2_reg <= double_block(l_dbl);
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == ST_OUT && out_free)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            out_mac_reg    <= (status_reg == STATUS_OK) ? tag_masked : 128'd0;
            out_status_reg <= status_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign mac_hi    = out_mac_reg[127:64];
    assign mac_lo    = out_mac_reg[63:0];
    assign status    = out_status_reg;

    acm_keyexp u_keyexp (
        .clk   (clk),
        .rst_n (rst_n),
        .start (kexp_start),
        .key   ({key_reg[0], key_reg[1], key_reg[2], key_reg[3]}),
        .nk    (nk),
        .wr    (rk_wr),
        .busy  (kexp_busy),
        .done  (kexp_done)
    );

    acm_keymem u_keymem (
        .clk     (clk),
        .wr      (rk_wr),
        .rd_addr (rk_addr),
        .rd_data (rk_data)
    );

    acm_cipher u_cipher (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cipher_start),
        .block_in ((state_reg == ST_SUBKEY) ? 128'd0 : cbc_in),
        .nr       (nr),
        .rk_data  (rk_data),
        .rd_addr  (rk_addr),
        .result   (cipher_out),
        .busy     (cipher_busy),
        .done     (cipher_done)
    );

    `ACM_ASSERT_IMP(a_block_has_subkeys, clk, rst_n, state_reg == ST_BLOCK, subkeys_ready_reg)
    `ACM_ASSERT_NEXT(a_launch_single, clk, rst_n, launch_reg, !launch_reg)
    `ACM_ASSERT_IMP(a_units_exclusive, clk, rst_n, cipher_busy, !kexp_busy)

endmodule

// ===== src/acm_keymem.sv =====
// Round key memory: 15 rows of four 32-bit words, word write, registered row read
module acm_keymem
    import acm_pkg::*;
(
    input  logic         clk,
    input  rk_wr_t       wr,
    input  logic [3:0]   rd_addr,
    output logic [127:0] rd_data
);

    logic [127:0] mem [RK_ROWS];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            case (wr.lane)
                2'd0:    mem[wr.row][127:96] <= wr.data;
                2'd1:    mem[wr.row][95:64]  <= wr.data;
                2'd2:    mem[wr.row][63:32]  <= wr.data;
                default: mem[wr.row][31:0]   <= wr.data;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== src/acm_keyexp.sv =====
// Key expansion sequencer: one round key word per cycle into the key memory
module acm_keyexp
    import acm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [255:0] key,
    input  logic [3:0]   nk,
    output rk_wr_t       wr,
    output logic         busy,
    output logic         done
);

    logic        busy_reg;
    logic        done_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  mod_reg;
    logic [7:0]  rcon_reg;
    logic [31:0] win_reg [8];

    logic [31:0] kw [8];
    logic [5:0]  last_idx;
    logic [2:0]  nk_m1;
    logic        expanding;
    logic [31:0] temp;
    logic [31:0] sub_in;
    logic [31:0] sub_out;
    logic [31:0] t2;
    logic [31:0] word;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
        begin
            kw[j] = key[255 - 32 * j -: 32];
        end
    end

    assign last_idx  = {nk, 2'b00} + 6'd27;
    assign nk_m1     = nk[2:0] - 3'd1;
    assign expanding = idx_reg >= {2'b00, nk};
    assign temp      = win_reg[0];
    assign sub_in    = (mod_reg == 3'd0) ? {temp[23:0], temp[31:24]} : temp;
    assign sub_out   = sub_word(sub_in);

    always_comb
    begin
        if (mod_reg == 3'd0)
            t2 = sub_out ^ {rcon_reg, 24'd0};
        else if (nk == 4'd8 && mod_reg == 3'd4)
            t2 = sub_out;
        else
            t2 = temp;
    end

    assign word = expanding ? (win_reg[nk_m1] ^ t2) : kw[idx_reg[2:0]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            idx_reg  <= '0;
            mod_reg  <= '0;
            rcon_reg <= 8'h01;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                mod_reg  <= '0;
                rcon_reg <= 8'h01;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 6'd1;
                if (expanding)
                begin
                    mod_reg <= (mod_reg == nk_m1) ? 3'd0 : mod_reg + 3'd1;
                    if (mod_reg == 3'd0)
                        rcon_reg <= xtime(rcon_reg);
                end
                if (idx_reg == last_idx)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            win_reg[0] <= word;
            for (int j = 1; j < 8; j++)
            begin
                win_reg[j] <= win_reg[j - 1];
            end
        end
    end

    assign wr.en   = busy_reg;
    assign wr.row  = idx_reg[5:2];
    assign wr.lane = idx_reg[1:0];
    assign wr.data = word;
    assign busy    = busy_reg;
    assign done    = done_reg;

endmodule

// ===== src/acm_cipher.sv =====
// AES block encryption, one round per cycle, round keys read from the key memory
module acm_cipher
    import acm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [127:0] block_in,
    input  logic [3:0]   nr,
    input  logic [127:0] rk_data,
    output logic [3:0]   rd_addr,
    output logic [127:0] result,
    output logic         busy,
    output logic         done
);

    logic         busy_reg;
    logic         done_reg;
    logic [3:0]   round_reg;
    logic [127:0] state_reg;

    assign rd_addr = start ? 4'd0 : round_reg + 4'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            round_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= '0;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 4'd1;
                if (round_reg == nr)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            state_reg <= block_in;
        else if (busy_reg)
        begin
            if (round_reg == 4'd0)
                state_reg <= state_reg ^ rk_data;
            else
                state_reg <= aes_round(state_reg, round_reg == nr) ^ rk_data;
        end
    end

    assign result = state_reg;
    assign busy   = busy_reg;
    assign done   = done_reg;

endmodule
